### design/dcs_pkg.sv
// Shared types, constants and the deadline ordering function of the deadline CPU selector.
package dcs_pkg;

   localparam int NumCpusDefault = 16;
   localparam int MaxCpus        = 16;
   localparam int MaskW          = 16;
   localparam int IdxW           = 4;
   localparam int DlW            = 64;
   localparam int CsrIdxW        = 1;
   localparam int CsrDataW       = 16;

   localparam logic [CsrIdxW-1:0] CsrOrderMode  = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrActiveCpus = 1'd1;

   typedef enum logic {
      OP_SET  = 1'b0,
      OP_FIND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_DEADLINE = 2'd1,
      ST_NONE     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CACHE_INVALID = 2'd0,
      CACHE_NONE    = 2'd1,
      CACHE_VALID   = 2'd2
   } cache_state_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic             go;
      logic [IdxW-1:0]  cpu;
      logic [DlW-1:0]   deadline;
      logic             busy;
   } dcs_set_type;

   typedef struct packed {
      logic [MaskW-1:0] free_mask;
      logic [MaskW-1:0] active_cpus;
      cache_state_type  cache_state;
      logic [IdxW-1:0]  cached_index;
      logic [DlW-1:0]   cached_dl;
      logic             order_mode;
   } dcs_view_type;

   // True when b is the better CPU deadline compared with a.
   function automatic logic better(input logic [DlW-1:0] a, input logic [DlW-1:0] b,
                                   input logic mode);
      logic [DlW-1:0] diff;
      diff = a - b;
      return mode ? (a > b) : diff[DlW-1];
   endfunction

endpackage

### design/dcs_if.sv
// Request and response channel interfaces of the deadline CPU selector.
interface dcs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [dcs_pkg::IdxW-1:0]      cpu_index;
   logic [dcs_pkg::DlW-1:0]       deadline;
   logic                          is_busy;
   logic                          task_present;
   logic                          want_mask;
   logic [dcs_pkg::MaskW-1:0]     allowed_mask;

   modport source (
      output valid, op, cpu_index, deadline, is_busy, task_present, want_mask, allowed_mask,
      input  ready
   );
   modport sink (
      input  valid, op, cpu_index, deadline, is_busy, task_present, want_mask, allowed_mask,
      output ready
   );
endinterface

interface dcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [dcs_pkg::IdxW-1:0]      target_cpu;
   logic [dcs_pkg::MaskW-1:0]     cpu_mask;

   modport source (
      output valid, status, target_cpu, cpu_mask,
      input  ready
   );
   modport sink (
      input  valid, status, target_cpu, cpu_mask,
      output ready
   );
endinterface

### design/dcs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module dcs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dcs_ctrl.sv
// Deadline table, free mask, best-CPU cache, configuration registers and the rescan sequencer.
module dcs_ctrl #(
   parameter int NUM_CPUS = dcs_pkg::NumCpusDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcs_pkg::dcs_set_type          set_req,
   input  logic                          csr_we,
   input  logic [dcs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dcs_pkg::CsrDataW-1:0]  csr_wdata,
   output logic                          idle,
   output dcs_pkg::dcs_view_type         view
);
   import dcs_pkg::*;

   localparam int CpuCount = (NUM_CPUS < MaxCpus) ? NUM_CPUS : MaxCpus;
   localparam int AW       = $clog2(CpuCount);
   localparam int CntW     = $clog2(CpuCount + 1);

   ctrl_state_type        state_ff, state_in;
   logic [MaskW-1:0]      free_ff, free_in;
   cache_state_type       cs_ff, cs_in;
   logic [IdxW-1:0]       cidx_ff, cidx_in;
   logic [DlW-1:0]        cdl_ff, cdl_in;
   logic                  mode_ff, mode_in;
   logic [MaskW-1:0]      active_ff, active_in;
   logic [IdxW-1:0]       cpu_ff, cpu_in;
   logic [DlW-1:0]        dl_ff, dl_in;
   logic                  busy_ff, busy_in;
   logic [CntW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  found_ff, found_in;
   logic [DlW-1:0]        best_dl_ff, best_dl_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;

   logic                  cpu_ok;
   logic                  need_rescan;
   logic                  rd_issue;
   logic                  scan_done;
   logic                  ram_we;
   logic [DlW-1:0]        ram_wdata;
   logic [DlW-1:0]        ram_rdata;
   logic [IdxW-1:0]       pend_cpu;

   assign cpu_ok      = ({1'b0, set_req.cpu} < (IdxW+1)'(CpuCount));
   assign need_rescan = (cs_ff == CACHE_INVALID) ||
                        ((cs_ff == CACHE_VALID) && (cidx_ff == set_req.cpu));
   assign rd_issue    = (state_ff == S_SCAN) && (rd_cnt_ff < CntW'(CpuCount));
   assign scan_done   = (state_ff == S_SCAN) && (rd_cnt_ff == CntW'(CpuCount)) && !pend_ff;
   assign pend_cpu    = IdxW'(pend_idx_ff);

   dcs_ram #(
      .WIDTH (DlW),
      .DEPTH (CpuCount)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (set_req.cpu[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (set_req.go && cpu_ok) begin
               if (need_rescan) begin
                  state_in = S_SCAN;
               end else if (set_req.busy) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = busy_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      idle      = (state_ff == S_IDLE);
      ram_we    = idle && set_req.go && cpu_ok;
      ram_wdata = set_req.busy ? set_req.deadline : '0;
   end

   always_comb begin
      free_in     = free_ff;
      cs_in       = cs_ff;
      cidx_in     = cidx_ff;
      cdl_in      = cdl_ff;
      mode_in     = mode_ff;
      active_in   = active_ff;
      cpu_in      = cpu_ff;
      dl_in       = dl_ff;
      busy_in     = busy_ff;
      rd_cnt_in   = rd_cnt_ff;
      pend_in     = rd_issue;
      pend_idx_in = rd_cnt_ff[AW-1:0];
      found_in    = found_ff;
      best_dl_in  = best_dl_ff;
      best_idx_in = best_idx_ff;

      if (csr_we) begin
         case (csr_index)
            CsrOrderMode:  mode_in   = csr_wdata[0];
            CsrActiveCpus: active_in = csr_wdata[MaskW-1:0];
            default: ;
         endcase
      end

      if (idle && set_req.go && cpu_ok) begin
         free_in[set_req.cpu] = !set_req.busy;
         cpu_in               = set_req.cpu;
         dl_in                = set_req.deadline;
         busy_in              = set_req.busy;
         rd_cnt_in            = '0;
         found_in             = 1'b0;
      end

      if (rd_issue) begin
         rd_cnt_in = rd_cnt_ff + CntW'(1);
      end

      if (pend_ff && !free_ff[pend_cpu] && (ram_rdata != '0)) begin
         if (!found_ff || better(best_dl_ff, ram_rdata, mode_ff)) begin
            found_in    = 1'b1;
            best_dl_in  = ram_rdata;
            best_idx_in = pend_idx_ff;
         end
      end

      if (scan_done) begin
         cs_in   = found_ff ? CACHE_VALID : CACHE_NONE;
         cidx_in = found_ff ? IdxW'(best_idx_ff) : '0;
         cdl_in  = best_dl_ff;
      end

      if (state_ff == S_FINISH) begin
         if (!((cs_ff == CACHE_VALID) && (cdl_ff != '0) && better(dl_ff, cdl_ff, mode_ff))) begin
            cs_in   = CACHE_VALID;
            cidx_in = cpu_ff;
            cdl_in  = dl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         free_ff   <= '1;
         cs_ff     <= CACHE_INVALID;
         cidx_ff   <= '0;
         mode_ff   <= 1'b0;
         active_ff <= '1;
         rd_cnt_ff <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         free_ff   <= free_in;
         cs_ff     <= cs_in;
         cidx_ff   <= cidx_in;
         mode_ff   <= mode_in;
         active_ff <= active_in;
         rd_cnt_ff <= rd_cnt_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cdl_ff      <= cdl_in;
      cpu_ff      <= cpu_in;
      dl_ff       <= dl_in;
      busy_ff     <= busy_in;
      pend_idx_ff <= pend_idx_in;
      best_dl_ff  <= best_dl_in;
      best_idx_ff <= best_idx_in;
   end

   assign view.free_mask    = free_ff;
   assign view.active_cpus  = active_ff;
   assign view.cache_state  = cs_ff;
   assign view.cached_index = cidx_ff;
   assign view.cached_dl    = cdl_ff;
   assign view.order_mode   = mode_ff;

   a_cached_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && (cs_ff == CACHE_VALID) |-> !free_ff[cidx_ff])
      else $error("Cached CPU is marked free while idle.");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == S_SCAN))
      else $error("Table read returned outside a rescan.");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CntW'(CpuCount))
      else $error("Rescan read counter ran past the table.");

   a_set_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !ram_we)
      else $error("Table written during a rescan.");

endmodule

### design/dcs_find.sv
// Find-operation selection logic and the response output register.
module dcs_find #(
   parameter int NUM_CPUS = dcs_pkg::NumCpusDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [dcs_pkg::DlW-1:0]    deadline,
   input  logic                       task_present,
   input  logic                       want_mask,
   input  logic [dcs_pkg::MaskW-1:0]  allowed_mask,
   input  dcs_pkg::dcs_view_type      view,
   dcs_rsp_if.source                  rsp
);
   import dcs_pkg::*;

   localparam int CpuCount = (NUM_CPUS < MaxCpus) ? NUM_CPUS : MaxCpus;

   logic [MaskW-1:0] span;
   logic [MaskW-1:0] allowed;
   logic [MaskW-1:0] avail;
   logic [IdxW-1:0]  lowest;
   status_type       status_c;
   logic [IdxW-1:0]  best_c;
   logic [MaskW-1:0] mask_c;

   logic             valid_ff, valid_in;
   status_type       status_ff;
   logic [IdxW-1:0]  best_ff;
   logic [MaskW-1:0] mask_ff;

   always_comb begin
      for (int i = 0; i < MaskW; i++) begin
         span[i] = (i < CpuCount);
      end
      allowed = allowed_mask & span;
      avail   = view.free_mask & allowed & view.active_cpus;
      lowest  = '0;
      for (int i = MaskW - 1; i >= 0; i--) begin
         if (avail[i]) begin
            lowest = IdxW'(i);
         end
      end
   end

   always_comb begin
      status_c = ST_NONE;
      best_c   = '0;
      mask_c   = '0;
      if (want_mask && (avail != '0)) begin
         status_c = ST_FREE;
         best_c   = lowest;
         mask_c   = avail;
      end
      if ((status_c != ST_FREE) && (view.cache_state == CACHE_VALID)) begin
         if (!task_present) begin
            status_c = ST_DEADLINE;
            best_c   = view.cached_index;
         end else if ((view.cached_dl != '0) && allowed[view.cached_index] &&
                      better(deadline, view.cached_dl, view.order_mode)) begin
            status_c = ST_DEADLINE;
            best_c   = view.cached_index;
            if (want_mask) begin
               mask_c = MaskW'(1) << view.cached_index;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_c;
         best_ff   <= best_c;
         mask_ff   <= mask_c;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.target_cpu = best_ff;
   assign rsp.cpu_mask   = mask_ff;

endmodule

### design/deadline_cpu_selector_unit.sv
// Top level of the deadline CPU selector: handshake control and the two datapath parts.
// A find's response is registered, valid in the cycle after its transfer; finds can follow
// each cycle unless a set is in progress or the response stalls. A set stays idle when it
// frees a CPU without a rescan; a rescan runs S_SCAN, and making a CPU busy adds S_FINISH.
// Reset is synchronous and active high: all CPUs free, cache invalid, registers at defaults.
// Unwritten table entries belong to free CPUs, which a rescan skips; the table is not cleared.
module deadline_cpu_selector_unit #(
   parameter int NUM_CPUS = dcs_pkg::NumCpusDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   dcs_req_if.sink                       req,
   dcs_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [dcs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dcs_pkg::CsrDataW-1:0]  csr_wdata
);
   import dcs_pkg::*;

   logic         idle;
   logic         req_xfer;
   logic         find_load;
   dcs_set_type  set_req;
   dcs_view_type view;

   assign req.ready = idle && (!rsp.valid || rsp.ready);
   assign req_xfer  = req.valid && req.ready;
   assign find_load = req_xfer && (req.op == OP_FIND);

   assign set_req.go       = req_xfer && (req.op == OP_SET);
   assign set_req.cpu      = req.cpu_index;
   assign set_req.deadline = req.deadline;
   assign set_req.busy     = req.is_busy;

   dcs_ctrl #(
      .NUM_CPUS (NUM_CPUS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .set_req   (set_req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .idle      (idle),
      .view      (view)
   );

   dcs_find #(
      .NUM_CPUS (NUM_CPUS)
   ) u_find (
      .clock        (clock),
      .reset        (reset),
      .load         (find_load),
      .deadline     (req.deadline),
      .task_present (req.task_present),
      .want_mask    (req.want_mask),
      .allowed_mask (req.allowed_mask),
      .view         (view),
      .rsp          (rsp)
   );

endmodule

### tb/deadline_cpu_selector_checker.sv
// Checker for the deadline CPU selector: tracks the CPU table and cache and compares each find result.
module deadline_cpu_selector_checker #(
   parameter int NUM_CPUS = dcs_pkg::NumCpusDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   dcs_req_if                            req,
   dcs_rsp_if                            rsp,
   input  logic                          csr_we,
   input  logic [dcs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dcs_pkg::CsrDataW-1:0]  csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import dcs_pkg::*;

   localparam int CpuCount = (NUM_CPUS < MaxCpus) ? NUM_CPUS : MaxCpus;
   localparam logic [MaskW-1:0] SpanMask =
      (CpuCount >= MaskW) ? '1 : MaskW'((32'd1 << CpuCount) - 32'd1);

   typedef struct packed {
      status_type        status;
      logic [IdxW-1:0]   target_cpu;
      logic [MaskW-1:0]  cpu_mask;
   } placement_type;

   logic [DlW-1:0]    cpu_dl [MaxCpus];
   logic [MaskW-1:0]  free_mask;
   logic [MaskW-1:0]  active_cpus;
   cache_state_type   cache_state;
   logic [IdxW-1:0]   cache_idx;
   logic              order_mode;
   placement_type     placement_q[$];

   // True when the candidate deadline cand ranks ahead of cur.
   function automatic logic preferred(input logic [DlW-1:0] cur, input logic [DlW-1:0] cand);
      logic [DlW-1:0] delta;
      delta = cur - cand;
      if (order_mode) return cur > cand;
      return delta[DlW-1];
   endfunction

   function automatic void rescan_cache();
      logic              found;
      logic [DlW-1:0]    best_dl;
      logic [IdxW-1:0]   best;
      found = 1'b0;
      best_dl = '0;
      best = '0;
      for (int i = 0; i < CpuCount; i++) begin
         if (!free_mask[i] && cpu_dl[i] != '0 && (!found || preferred(best_dl, cpu_dl[i]))) begin
            found = 1'b1;
            best_dl = cpu_dl[i];
            best = IdxW'(i);
         end
      end
      cache_state = found ? CACHE_VALID : CACHE_NONE;
      cache_idx = found ? best : '0;
   endfunction

   function automatic void apply_set(input logic [IdxW-1:0] cpu, input logic [DlW-1:0] dl,
                                     input logic busy);
      logic keep;
      if (int'(cpu) >= CpuCount) return;
      if (busy) begin
         free_mask[cpu] = 1'b0;
         cpu_dl[cpu] = dl;
         if (cache_state == CACHE_INVALID || (cache_state == CACHE_VALID && cache_idx == cpu))
            rescan_cache();
         keep = cache_state == CACHE_VALID && cpu_dl[cache_idx] != '0 &&
                preferred(dl, cpu_dl[cache_idx]);
         if (!keep) begin
            cache_state = CACHE_VALID;
            cache_idx = cpu;
         end
      end else begin
         free_mask[cpu] = 1'b1;
         cpu_dl[cpu] = '0;
         if (cache_state == CACHE_INVALID || (cache_state == CACHE_VALID && cache_idx == cpu))
            rescan_cache();
      end
   endfunction

   function automatic placement_type predict_find(input logic [DlW-1:0] dl, input logic push,
                                                  input logic want,
                                                  input logic [MaskW-1:0] allowed_in);
      placement_type     p;
      logic [MaskW-1:0]  allowed;
      logic [MaskW-1:0]  avail;
      logic [IdxW-1:0]   c;
      p.status = ST_NONE;
      p.target_cpu = '0;
      p.cpu_mask = '0;
      allowed = allowed_in & SpanMask;
      if (want) begin
         avail = free_mask & allowed & active_cpus & SpanMask;
         if (avail != '0) begin
            p.status = ST_FREE;
            p.cpu_mask = avail;
            for (int i = CpuCount - 1; i >= 0; i--)
               if (avail[i]) p.target_cpu = IdxW'(i);
         end
      end
      if (p.status != ST_FREE && cache_state == CACHE_VALID) begin
         c = cache_idx;
         if (!push) begin
            p.status = ST_DEADLINE;
            p.target_cpu = c;
         end else if (cpu_dl[c] != '0 && allowed[c] && preferred(dl, cpu_dl[c])) begin
            p.status = ST_DEADLINE;
            p.target_cpu = c;
            if (want) p.cpu_mask = MaskW'(1) << c;
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      placement_type oldest;
      if (reset) begin
         for (int i = 0; i < MaxCpus; i++) cpu_dl[i] = '0;
         free_mask = '1;
         active_cpus = '1;
         cache_state = CACHE_INVALID;
         cache_idx = '0;
         order_mode = 1'b0;
         placement_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CsrOrderMode) order_mode = csr_wdata[0];
            else if (csr_index == CsrActiveCpus) active_cpus = csr_wdata[MaskW-1:0];
         end
         if (rsp.valid && rsp.ready) begin
            if (placement_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result transfer: status %0d cpu %0d mask %h",
                           $realtime, rsp.status, rsp.target_cpu, rsp.cpu_mask);
            end else begin
               oldest = placement_q.pop_front();
               if (rsp.status !== oldest.status || rsp.target_cpu !== oldest.target_cpu ||
                   rsp.cpu_mask !== oldest.cpu_mask) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected/actual status %0d/%0d cpu %0d/%0d mask %h/%h",
                              $realtime, oldest.status, rsp.status, oldest.target_cpu,
                              rsp.target_cpu, oldest.cpu_mask, rsp.cpu_mask);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_SET)
               apply_set(req.cpu_index, req.deadline, req.is_busy);
            else
               placement_q.push_back(predict_find(req.deadline, req.task_present, req.want_mask,
                                                  req.allowed_mask));
         end
      end
      pending = placement_q.size();
   end

endmodule

### tb/deadline_cpu_selector_unit_tb.sv
// Testbench top for the deadline CPU selector: clock, reset, register setup, stimulus and verdict.
module deadline_cpu_selector_unit_tb;
   import dcs_pkg::*;

   localparam int CycleLimit    = 200000;
   localparam int SettleCycles  = 40;
   localparam int PhaseCount    = 5;
   localparam int ItemsPerPhase = 90;

   typedef struct packed {
      op_type            op;
      logic [IdxW-1:0]   cpu_index;
      logic [DlW-1:0]    deadline;
      logic              is_busy;
      logic              task_present;
      logic              want_mask;
      logic [MaskW-1:0]  allowed_mask;
   } sched_req_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIdxW-1:0]   csr_index;
   logic [CsrDataW-1:0]  csr_wdata;
   int                   fail_count;
   int                   pending;
   int unsigned          cycle_count = 0;
   int                   burst_left = 0;
   int                   sink_mode = 0;
   int                   sink_left = 0;
   logic [DlW-1:0]       dl_base;

   dcs_req_if req_ch();
   dcs_rsp_if rsp_ch();

   deadline_cpu_selector_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deadline_cpu_selector_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CycleLimit);
      $display("Verification failed");
      $finish;
   end

   // The response side changes its stall pattern whenever its countdown runs out.
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= $urandom_range(0, 3);
         sink_left <= $urandom_range(8, 64);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= (sink_left % 4 == 0);
         default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic program_regs(input logic mode, input logic [CsrDataW-1:0] active);
      csr_we <= 1'b1;
      csr_index <= CsrOrderMode;
      csr_wdata <= CsrDataW'(mode);
      @(posedge clock);
      csr_index <= CsrActiveCpus;
      csr_wdata <= active;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_request(input sched_req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= item.op;
      req_ch.cpu_index <= item.cpu_index;
      req_ch.deadline <= item.deadline;
      req_ch.is_busy <= item.is_busy;
      req_ch.task_present <= item.task_present;
      req_ch.want_mask <= item.want_mask;
      req_ch.allowed_mask <= item.allowed_mask;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
   endtask

   function automatic sched_req_type random_request();
      sched_req_type r;
      r.op = ($urandom_range(0, 99) < 55) ? OP_SET : OP_FIND;
      r.cpu_index = IdxW'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
         0: r.deadline = '0;
         1: r.deadline = {$urandom, $urandom};
         default: r.deadline = dl_base + DlW'($urandom_range(0, 63));
      endcase
      r.is_busy = ($urandom_range(0, 9) < 7);
      r.task_present = 1'($urandom_range(0, 1));
      r.want_mask = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: r.allowed_mask = '1;
         1: r.allowed_mask = MaskW'(1) << $urandom_range(0, 15);
         2: r.allowed_mask = MaskW'($urandom);
         default: r.allowed_mask = ~(MaskW'(1) << $urandom_range(0, 15));
      endcase
      return r;
   endfunction

   initial begin
      logic              mode;
      logic [MaskW-1:0]  active;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CsrOrderMode;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = OP_SET;
      req_ch.cpu_index = '0;
      req_ch.deadline = '0;
      req_ch.is_busy = 1'b0;
      req_ch.task_present = 1'b0;
      req_ch.want_mask = 1'b0;
      req_ch.allowed_mask = '0;
      dl_base = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PhaseCount; ph++) begin
         case (ph)
            0: begin
               mode = 1'b0;
               active = '1;
               dl_base = {$urandom, $urandom};
            end
            1: begin
               mode = 1'b1;
               active = '1;
               dl_base = {$urandom, $urandom};
            end
            2: begin
               mode = 1'b0;
               active = MaskW'($urandom);
               dl_base = 64'hFFFF_FFFF_FFFF_FFC0;
            end
            3: begin
               mode = 1'b1;
               active = '0;
               dl_base = 64'h7FFF_FFFF_FFFF_FFE0;
            end
            default: begin
               mode = 1'b0;
               active = MaskW'($urandom) | 16'h8001;
               dl_base = '0;
            end
         endcase
         program_regs(mode, active);

         if (ph == 0) begin
            // The cache starts out invalid, so finds fall back to free CPUs or none.
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd0, 1'b0, 1'b1, 1'b1, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
                                         1'b1, 16'h0000});
            send_request(sched_req_type'{OP_SET, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0,
                                         1'b0, 16'h0000});
            send_request(sched_req_type'{OP_SET, 4'd0, 64'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF});
            send_request(sched_req_type'{OP_SET, 4'd7, 64'h8000_0000_0000_0000, 1'b1, 1'b0,
                                         1'b0, 16'h0000});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd5, 1'b0, 1'b0, 1'b0, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd0, 1'b0, 1'b1, 1'b1, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd1, 1'b0, 1'b1, 1'b0, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd1, 1'b0, 1'b1, 1'b0, 16'h0000});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                                         1'b1, 16'h8080});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                                         1'b1, 16'h8001});
            send_request(sched_req_type'{OP_SET, 4'd15, 64'd5, 1'b1, 1'b0, 1'b0, 16'h0000});
            send_request(sched_req_type'{OP_SET, 4'd7, 64'd9, 1'b0, 1'b0, 1'b0, 16'h0000});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1, 16'h8001});
            send_request(sched_req_type'{OP_SET, 4'd15, 64'd0, 1'b0, 1'b0, 1'b0, 16'h0000});
            send_request(sched_req_type'{OP_SET, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0, 16'h0000});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'd3, 1'b0, 1'b1, 1'b0, 16'hFFFF});
            send_request(sched_req_type'{OP_SET, 4'd3, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1,
                                         1'b1, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                                         1'b1, 16'hFFFF});
            send_request(sched_req_type'{OP_FIND, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                                         1'b0, 16'h0008});
         end

         for (int n = 0; n < ItemsPerPhase; n++)
            send_request(random_request());

         req_ch.valid <= 1'b0;
         burst_left = 0;
         @(posedge clock);
         wait (pending == 0);
         repeat (SettleCycles) @(posedge clock);
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
design/dcs_pkg.sv
design/dcs_if.sv
design/dcs_ram.sv
design/dcs_ctrl.sv
design/dcs_find.sv
design/deadline_cpu_selector_unit.sv
tb/deadline_cpu_selector_checker.sv
tb/deadline_cpu_selector_unit_tb.sv
